>>> hw/rtl/ppm_pp_pkg.sv
// Shared types and constants for the P3 ASCII pixel parser.
// Result word layout, result kinds, error codes and character codes.
// No dependencies.
package ppm_pp_pkg;

   localparam int MaxPixelsDefault = 1048576;
   localparam logic [2:0] DigitLimit = 3'd7;
   localparam int FifoDepth = 4;
   localparam int PtrW = $clog2(FifoDepth);
   localparam int CountW = $clog2(FifoDepth + 1);

   localparam logic [7:0] CharP     = 8'h50;
   localparam logic [7:0] Char3     = 8'h33;
   localparam logic [7:0] CharHash  = 8'h23;
   localparam logic [7:0] CharLf    = 8'h0A;
   localparam logic [7:0] CharTab   = 8'h09;
   localparam logic [7:0] CharVt    = 8'h0B;
   localparam logic [7:0] CharFf    = 8'h0C;
   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] AlphaByte = 8'hFF;

   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_MAGIC     = 3'd1,
      ERR_DIGITS    = 3'd2,
      ERR_OVER_MAX  = 3'd3,
      ERR_COUNT     = 3'd4,
      ERR_HEADER    = 3'd5,
      ERR_TOO_BIG   = 3'd6
   } err_type;

   typedef struct packed {
      kind_type    kind;
      logic [21:0] addr;
      logic [7:0]  value;
      logic [23:0] width;
      logic [23:0] height;
      logic [23:0] maxval;
      err_type     err;
      logic        last;
   } result_type;

endpackage

>>> hw/rtl/ppm_ascii_pixel_parser_top.sv
// Each result word is registered in the result queue and offered on rsp_ in order of arrival.
// Throughput: one input word per cycle while req_stall is low; a word that ends the third
// channel of a pixel yields two results (channel and alpha), offered as two rsp_ words.
// req_stall rises while the four-entry result queue has fewer than two free entries.
// Reset (synchronous, active high) clears the parse state and empties the result queue.
// Top level of the P3 ASCII pixel parser; depends on ppm_pp_pkg.
module ppm_ascii_pixel_parser_top #(
   parameter int MAX_PIXELS = ppm_pp_pkg::MaxPixelsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_char_code,
   input  logic                 req_end_of_input,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ppm_pp_pkg::kind_type rsp_result_kind,
   output logic [21:0]          rsp_byte_address,
   output logic [7:0]           rsp_channel_value,
   output logic [23:0]          rsp_image_width,
   output logic [23:0]          rsp_image_height,
   output logic [23:0]          rsp_max_value,
   output ppm_pp_pkg::err_type  rsp_error_code,
   output logic                 rsp_last_of_run
);
   import ppm_pp_pkg::*;

   localparam int RowW = $clog2(MAX_PIXELS + 2);

   typedef enum logic [1:0] {
      PS_WANT_P,
      PS_WANT_3,
      PS_BODY
   } pstate_type;

   typedef struct packed {
      logic [21:0]     addr;
      logic [21:0]     seen;
      logic [25:0]     col;
      logic [RowW-1:0] row;
   } wctr_type;

   function automatic wctr_type advance_write(wctr_type cur, logic [25:0] row_bytes,
                                              logic [23:0] height);
      wctr_type    nxt;
      logic [25:0] col_inc;
      col_inc  = cur.col + 26'd1;
      nxt      = cur;
      nxt.addr = cur.addr + 22'd1;
      nxt.seen = cur.seen + 22'd1;
      nxt.col  = col_inc;
      if (col_inc == row_bytes) begin
         nxt.col = '0;
         if (24'(cur.row) <= height) begin
            nxt.row  = cur.row + RowW'(1);
            nxt.addr = nxt.addr - {row_bytes[20:0], 1'b0};
         end
      end
      return nxt;
   endfunction

   pstate_type      pstate_ff, pstate_in;
   logic            comment_ff, comment_in;
   logic            number_ff, number_in;
   logic [2:0]      digits_ff, digits_in;
   logic [23:0]     accum_ff, accum_in;
   logic [1:0]      field_ff, field_in;
   logic [23:0]     width_ff, width_in;
   logic [23:0]     height_ff, height_in;
   logic [23:0]     maxval_ff, maxval_in;
   logic [1:0]      chan_ff, chan_in;
   wctr_type        ctr_ff, ctr_in;
   err_type         error_ff, error_in;
   logic [47:0]     product_ff;
   logic [CountW-1:0] count_ff, count_in;
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   result_type      fifo_ff [FifoDepth];

   logic            req_accept;
   logic            rsp_pop;
   logic [1:0]      push_cnt;
   result_type      res0, res1;
   wctr_type        ctr_a, ctr_b;
   logic [25:0]     row_bytes;
   logic [49:0]     store_bytes;
   logic            is_digit;
   logic            is_space;
   logic            too_big;
   err_type         status_err;

   assign req_accept  = req_valid && !req_stall;
   assign rsp_pop     = rsp_valid && !rsp_stall;
   assign req_stall   = count_ff > CountW'(FifoDepth - 2);
   assign row_bytes   = {width_ff, 2'b00};
   assign store_bytes = {product_ff, 2'b00};
   assign too_big     = product_ff > 48'(MAX_PIXELS);
   assign is_digit    = (req_char_code >= CharZero) && (req_char_code <= CharNine);
   assign is_space    = (req_char_code == CharSpace) || (req_char_code == CharTab) ||
                        (req_char_code == CharLf) || (req_char_code == CharVt) ||
                        (req_char_code == CharFf) || (req_char_code == CharCr);
   assign ctr_a       = advance_write(ctr_ff, row_bytes, height_ff);
   assign ctr_b       = advance_write(ctr_a, row_bytes, height_ff);

   always_comb begin
      if (error_ff != ERR_NONE) begin
         status_err = error_ff;
      end else if (pstate_ff != PS_BODY) begin
         status_err = ERR_MAGIC;
      end else if (field_ff != 2'd3) begin
         status_err = ERR_HEADER;
      end else if ({28'd0, ctr_ff.seen} != store_bytes) begin
         status_err = ERR_COUNT;
      end else begin
         status_err = ERR_NONE;
      end
   end

   always_comb begin
      pstate_in  = pstate_ff;
      comment_in = comment_ff;
      number_in  = number_ff;
      digits_in  = digits_ff;
      accum_in   = accum_ff;
      field_in   = field_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      maxval_in  = maxval_ff;
      chan_in    = chan_ff;
      ctr_in     = ctr_ff;
      error_in   = error_ff;
      push_cnt   = 2'd0;
      res0        = '0;
      res0.width  = width_ff;
      res0.height = height_ff;
      res0.maxval = maxval_ff;
      res0.last   = 1'b1;
      res1        = res0;
      if (req_accept) begin
         if (req_end_of_input) begin
            res0.kind  = KIND_STATUS;
            res0.err   = status_err;
            push_cnt   = 2'd1;
            pstate_in  = PS_WANT_P;
            comment_in = 1'b0;
            number_in  = 1'b0;
            digits_in  = '0;
            accum_in   = '0;
            field_in   = '0;
            width_in   = '0;
            height_in  = '0;
            maxval_in  = '0;
            chan_in    = '0;
            ctr_in     = '0;
            ctr_in.row = RowW'(1);
            error_in   = ERR_NONE;
         end else if (error_ff == ERR_NONE) begin
            case (pstate_ff)
               PS_WANT_P: begin
                  if (req_char_code != CharP) error_in = ERR_MAGIC;
                  else pstate_in = PS_WANT_3;
               end
               PS_WANT_3: begin
                  if (req_char_code != Char3) error_in = ERR_MAGIC;
                  else pstate_in = PS_BODY;
               end
               PS_BODY: begin
                  if (req_char_code == CharHash) begin
                     comment_in = 1'b1;
                  end else if (comment_ff) begin
                     if (req_char_code == CharLf) comment_in = 1'b0;
                  end else if (is_digit) begin
                     number_in = 1'b1;
                     if (digits_ff >= DigitLimit) begin
                        error_in = ERR_DIGITS;
                     end else begin
                        accum_in  = {accum_ff[20:0], 3'b000} + {accum_ff[22:0], 1'b0} +
                                    {20'd0, req_char_code[3:0]};
                        digits_in = digits_ff + 3'd1;
                     end
                  end else if (is_space && number_ff) begin
                     number_in = 1'b0;
                     digits_in = '0;
                     accum_in  = '0;
                     case (field_ff)
                        2'd0: begin
                           width_in = accum_ff;
                           field_in = 2'd1;
                        end
                        2'd1: begin
                           height_in = accum_ff;
                           field_in  = 2'd2;
                        end
                        2'd2: begin
                           maxval_in   = accum_ff;
                           field_in    = 2'd3;
                           if (too_big) error_in = ERR_TOO_BIG;
                           ctr_in.addr = (height_ff == 24'd0) ? 22'd0 :
                                         {product_ff[19:0] - width_ff[19:0], 2'b00};
                           ctr_in.seen = '0;
                           ctr_in.col  = '0;
                           ctr_in.row  = RowW'(1);
                           chan_in     = '0;
                           res0.kind   = KIND_HEADER;
                           res0.maxval = accum_ff;
                           res0.err    = too_big ? ERR_TOO_BIG : ERR_NONE;
                           push_cnt    = 2'd1;
                        end
                        default: begin
                           if (accum_ff > maxval_ff) begin
                              error_in = ERR_OVER_MAX;
                           end else if ({28'd0, ctr_ff.seen} >= store_bytes) begin
                              error_in = ERR_COUNT;
                           end else begin
                              res0.kind  = KIND_WRITE;
                              res0.addr  = ctr_ff.addr;
                              res0.value = accum_ff[7:0];
                              if (chan_ff == 2'd2) begin
                                 res0.last  = 1'b0;
                                 res1.kind  = KIND_WRITE;
                                 res1.addr  = ctr_a.addr;
                                 res1.value = AlphaByte;
                                 chan_in    = '0;
                                 ctr_in     = ctr_b;
                                 push_cnt   = 2'd2;
                              end else begin
                                 chan_in  = chan_ff + 2'd1;
                                 ctr_in   = ctr_a;
                                 push_cnt = 2'd1;
                              end
                           end
                        end
                     endcase
                  end
               end
               default: begin
                  pstate_in = PS_WANT_P;
               end
            endcase
         end
      end
   end

   assign count_in = count_ff + CountW'(push_cnt) - CountW'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         pstate_ff  <= PS_WANT_P;
         comment_ff <= 1'b0;
         number_ff  <= 1'b0;
         digits_ff  <= '0;
         accum_ff   <= '0;
         field_ff   <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         maxval_ff  <= '0;
         chan_ff    <= '0;
         ctr_ff     <= '{addr: '0, seen: '0, col: '0, row: RowW'(1)};
         error_ff   <= ERR_NONE;
         product_ff <= '0;
         count_ff   <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
      end else begin
         pstate_ff  <= pstate_in;
         comment_ff <= comment_in;
         number_ff  <= number_in;
         digits_ff  <= digits_in;
         accum_ff   <= accum_in;
         field_ff   <= field_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         maxval_ff  <= maxval_in;
         chan_ff    <= chan_in;
         ctr_ff     <= ctr_in;
         error_ff   <= error_in;
         product_ff <= width_ff * height_ff;
         count_ff   <= count_in;
         wr_ptr_ff  <= wr_ptr_ff + PtrW'(push_cnt);
         if (rsp_pop) rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) fifo_ff[wr_ptr_ff] <= res0;
      if (push_cnt == 2'd2) fifo_ff[wr_ptr_ff + PtrW'(1)] <= res1;
   end

   assign rsp_valid         = count_ff != '0;
   assign rsp_result_kind   = fifo_ff[rd_ptr_ff].kind;
   assign rsp_byte_address  = fifo_ff[rd_ptr_ff].addr;
   assign rsp_channel_value = fifo_ff[rd_ptr_ff].value;
   assign rsp_image_width   = fifo_ff[rd_ptr_ff].width;
   assign rsp_image_height  = fifo_ff[rd_ptr_ff].height;
   assign rsp_max_value     = fifo_ff[rd_ptr_ff].maxval;
   assign rsp_error_code    = fifo_ff[rd_ptr_ff].err;
   assign rsp_last_of_run   = fifo_ff[rd_ptr_ff].last;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(FifoDepth))
      else $error("result queue over capacity");

   a_eof_restart: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_end_of_input |=> pstate_ff == PS_WANT_P && error_ff == ERR_NONE
         && field_ff == 2'd0)
      else $error("end of input did not restart the parser");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_STATUS |-> rsp_last_of_run)
      else $error("status word not marked last");

endmodule

>>> sim/ppm_ascii_pixel_parser_checker.sv
// Result checker for the P3 ASCII pixel parser: follows every accepted req_ word,
// keeps its own copy of the parse state and compares each rsp_ word in order.
// Depends on ppm_pp_pkg.
`timescale 1ns / 100ps
module ppm_ascii_pixel_parser_checker
   import ppm_pp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_input,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  kind_type    rsp_result_kind,
   input  logic [21:0] rsp_byte_address,
   input  logic [7:0]  rsp_channel_value,
   input  logic [23:0] rsp_image_width,
   input  logic [23:0] rsp_image_height,
   input  logic [23:0] rsp_max_value,
   input  err_type     rsp_error_code,
   input  logic        rsp_last_of_run,
   output int          mismatches,
   output int          pending
);

   localparam int ChannelsPerPixel = 3;

   typedef enum logic [1:0] {
      SEEK_P,
      SEEK_3,
      IN_BODY
   } magic_stage_type;

   typedef enum logic [1:0] {
      FIELD_W,
      FIELD_H,
      FIELD_MAX,
      FIELD_DONE
   } header_field_type;

   magic_stage_type  stage;
   header_field_type field_idx;
   logic             in_remark;
   logic             in_digits;
   logic [2:0]       digit_cnt;
   logic [23:0]      accum;
   logic [23:0]      img_w;
   logic [23:0]      img_h;
   logic [23:0]      img_max;
   logic [1:0]       chan_idx;
   logic [21:0]      wr_addr;
   int unsigned      row_num;
   logic [21:0]      bytes_done;
   err_type          sticky;
   result_type       results_due[$];

   initial begin
      mismatches = 0;
      pending = 0;
   end

   function automatic void restart_parse();
      stage = SEEK_P;
      field_idx = FIELD_W;
      in_remark = 1'b0;
      in_digits = 1'b0;
      digit_cnt = '0;
      accum = '0;
      img_w = '0;
      img_h = '0;
      img_max = '0;
      chan_idx = '0;
      wr_addr = '0;
      row_num = 1;
      bytes_done = '0;
      sticky = ERR_NONE;
   endfunction

   function automatic longint unsigned store_size();
      longint unsigned s;
      s = img_w;
      return s * img_h * 4;
   endfunction

   function automatic void emit(kind_type kind, logic [21:0] addr, logic [7:0] value,
                                err_type err);
      result_type r;
      r.kind = kind;
      r.addr = addr;
      r.value = value;
      r.width = img_w;
      r.height = img_h;
      r.maxval = img_max;
      r.err = err;
      r.last = 1'b0;
      results_due.push_back(r);
   endfunction

   function automatic void store_byte(logic [7:0] value);
      logic [31:0] row_len;
      logic [31:0] rewind;
      row_len = {6'b0, img_w, 2'b00};
      emit(KIND_WRITE, wr_addr, value, ERR_NONE);
      wr_addr = wr_addr + 1'b1;
      bytes_done = bytes_done + 1'b1;
      // end of a row: step back to the start of the row below
      if (row_len != 0 && bytes_done % row_len == 0 && row_num <= img_h) begin
         row_num++;
         rewind = row_len << 1;
         wr_addr = wr_addr - rewind[21:0];
      end
   endfunction

   function automatic void close_number();
      logic [23:0]     v;
      longint unsigned area;
      longint unsigned top_row;
      v = accum;
      in_digits = 1'b0;
      digit_cnt = '0;
      accum = '0;
      case (field_idx)
         FIELD_W: begin
            img_w = v;
            field_idx = FIELD_H;
         end
         FIELD_H: begin
            img_h = v;
            field_idx = FIELD_MAX;
         end
         FIELD_MAX: begin
            img_max = v;
            field_idx = FIELD_DONE;
            area = img_w;
            area = area * img_h;
            if (area > MaxPixelsDefault) sticky = ERR_TOO_BIG;
            top_row = img_h;
            if (img_h != 0) top_row = (top_row - 1) * img_w * 4;
            wr_addr = top_row[21:0];
            row_num = 1;
            bytes_done = '0;
            chan_idx = '0;
            emit(KIND_HEADER, '0, '0, sticky);
         end
         default: begin
            if (v > img_max) begin
               sticky = ERR_OVER_MAX;
            end else if (64'(bytes_done) >= store_size()) begin
               sticky = ERR_COUNT;
            end else begin
               store_byte(v[7:0]);
               chan_idx++;
               if (chan_idx == ChannelsPerPixel) begin
                  store_byte(AlphaByte);
                  chan_idx = '0;
               end
            end
         end
      endcase
   endfunction

   function automatic void parse_word(logic [7:0] c, logic eof);
      int         prior_count;
      err_type    status;
      result_type r;
      prior_count = results_due.size();
      if (eof) begin
         status = sticky;
         if (status == ERR_NONE) begin
            if (stage != IN_BODY) status = ERR_MAGIC;
            else if (field_idx != FIELD_DONE) status = ERR_HEADER;
            else if (64'(bytes_done) != store_size()) status = ERR_COUNT;
         end
         emit(KIND_STATUS, '0, '0, status);
         restart_parse();
      end else if (sticky == ERR_NONE) begin
         if (stage == SEEK_P) begin
            if (c == CharP) stage = SEEK_3;
            else sticky = ERR_MAGIC;
         end else if (stage == SEEK_3) begin
            if (c == Char3) stage = IN_BODY;
            else sticky = ERR_MAGIC;
         end else if (c == CharHash) begin
            in_remark = 1'b1;
         end else if (in_remark) begin
            if (c == CharLf) in_remark = 1'b0;
         end else if (c >= CharZero && c <= CharNine) begin
            in_digits = 1'b1;
            if (digit_cnt >= DigitLimit) begin
               sticky = ERR_DIGITS;
            end else begin
               accum = 24'(accum * 10 + (c - CharZero));
               digit_cnt++;
            end
         end else if (c == CharSpace || (c >= CharTab && c <= CharCr)) begin
            if (in_digits) close_number();
         end
      end
      // flag the final result of this word
      if (results_due.size() > prior_count) begin
         r = results_due.pop_back();
         r.last = 1'b1;
         results_due.push_back(r);
      end
   endfunction

   function automatic void check_field(string field, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : track
      result_type want;
      if (reset) begin
         restart_parse();
         results_due.delete();
      end else begin
         if (req_valid && !req_stall) parse_word(req_char_code, req_end_of_input);
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $error("result_kind: expected no word, got %0d", rsp_result_kind);
               mismatches++;
            end else begin
               want = results_due.pop_front();
               check_field("result_kind", want.kind, rsp_result_kind);
               check_field("byte_address", want.addr, rsp_byte_address);
               check_field("channel_value", want.value, rsp_channel_value);
               check_field("image_width", want.width, rsp_image_width);
               check_field("image_height", want.height, rsp_image_height);
               check_field("max_value", want.maxval, rsp_max_value);
               check_field("error_code", want.err, rsp_error_code);
               check_field("last_of_run", want.last, rsp_last_of_run);
            end
         end
      end
      pending = results_due.size();
   end

endmodule

>>> sim/ppm_ascii_pixel_parser_top_tb.sv
// Testbench top for the P3 ASCII pixel parser: builds P3 files byte by byte,
// drives them with random idling on both sides and gives the verdict.
// Depends on ppm_pp_pkg, ppm_ascii_pixel_parser_top and ppm_ascii_pixel_parser_checker.
`timescale 1ns / 100ps
module ppm_ascii_pixel_parser_top_tb;
   import ppm_pp_pkg::*;

   localparam int RandomWords = 1080;
   localparam int CalmTailWords = 150;

   typedef enum int {
      FLAW_NONE,
      FLAW_EXTRA,
      FLAW_SHORT,
      FLAW_OVER,
      FLAW_DIGITS,
      FLAW_OPEN_END,
      FLAW_HEADER,
      FLAW_MAGIC
   } flaw_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = '0;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   kind_type    rsp_result_kind;
   logic [21:0] rsp_byte_address;
   logic [7:0]  rsp_channel_value;
   logic [23:0] rsp_image_width;
   logic [23:0] rsp_image_height;
   logic [23:0] rsp_max_value;
   err_type     rsp_error_code;
   logic        rsp_last_of_run;
   int          mismatches;
   int          pending;

   bit          calm = 1'b0;
   int          stall_left = 0;
   int          words_sent = 0;
   int          directed_words;
   logic [7:0]  file_text[$];

   ppm_ascii_pixel_parser_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .req_end_of_input  (req_end_of_input),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_byte_address  (rsp_byte_address),
      .rsp_channel_value (rsp_channel_value),
      .rsp_image_width   (rsp_image_width),
      .rsp_image_height  (rsp_image_height),
      .rsp_max_value     (rsp_max_value),
      .rsp_error_code    (rsp_error_code),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   ppm_ascii_pixel_parser_checker result_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .req_end_of_input  (req_end_of_input),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_byte_address  (rsp_byte_address),
      .rsp_channel_value (rsp_channel_value),
      .rsp_image_width   (rsp_image_width),
      .rsp_image_height  (rsp_image_height),
      .rsp_max_value     (rsp_max_value),
      .rsp_error_code    (rsp_error_code),
      .rsp_last_of_run   (rsp_last_of_run),
      .mismatches        (mismatches),
      .pending           (pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 10);
      end
   end

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) file_text.push_back(s[i]);
   endfunction

   function automatic logic [7:0] junk_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while ((b >= CharZero && b <= CharNine) || b == CharHash || b == CharSpace ||
             (b >= CharTab && b <= CharCr));
      return b;
   endfunction

   function automatic void put_comment();
      logic [7:0] b;
      file_text.push_back(CharHash);
      repeat ($urandom_range(0, 6)) begin
         b = 8'($urandom_range(0, 255));
         if (b != CharLf) file_text.push_back(b);
      end
      file_text.push_back(CharLf);
   endfunction

   function automatic void put_gap();
      case ($urandom_range(0, 9))
         0: put_comment();
         1: file_text.push_back(junk_byte());
         default: ;
      endcase
      repeat ($urandom_range(1, 2)) begin
         case ($urandom_range(0, 9))
            0: file_text.push_back(CharTab);
            1: file_text.push_back(CharLf);
            2: file_text.push_back(CharVt);
            3: file_text.push_back(CharFf);
            4: file_text.push_back(CharCr);
            default: file_text.push_back(CharSpace);
         endcase
      end
   endfunction

   // decimal text, with leading zeros or a comment or junk byte inside at times
   function automatic void put_number(longint unsigned v);
      string digits;
      int    pad;
      int    cut;
      digits = $sformatf("%0d", v);
      pad = 0;
      if (digits.len() < 7 && $urandom_range(0, 5) == 0)
         pad = $urandom_range(0, 7 - digits.len());
      cut = 0;
      if (digits.len() > 1 && $urandom_range(0, 7) == 0) cut = $urandom_range(1, digits.len() - 1);
      repeat (pad) file_text.push_back(CharZero);
      for (int i = 0; i < digits.len(); i++) begin
         if (cut != 0 && i == cut) begin
            if ($urandom_range(0, 1)) put_comment();
            else file_text.push_back(junk_byte());
         end
         file_text.push_back(digits[i]);
      end
   endfunction

   function automatic void build_random_file();
      int              pick;
      int              w;
      int              h;
      int              maxv;
      int              n_chan;
      int              hit;
      flaw_type        flaw;
      longint unsigned v;
      pick = $urandom_range(0, 99);
      flaw = FLAW_NONE;
      if ($urandom_range(0, 2) == 0) flaw = flaw_type'($urandom_range(FLAW_EXTRA, FLAW_MAGIC));
      if (pick < 65) begin
         if (flaw == FLAW_MAGIC) put_text($urandom_range(0, 1) ? "P6" : "p3");
         else put_text("P3");
         put_gap();
         w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, ($urandom_range(0, 3) == 0) ? 4 : 2);
         h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, ($urandom_range(0, 3) == 0) ? 4 : 2);
         case ($urandom_range(0, 5))
            0: maxv = 0;
            1: maxv = 1;
            2: maxv = 255;
            3: maxv = $urandom_range(256, 65535);
            4: maxv = 9999999;
            default: maxv = $urandom_range(0, 300);
         endcase
         put_number(w);
         put_gap();
         put_number(h);
         if (flaw != FLAW_HEADER) begin
            put_gap();
            put_number(maxv);
            put_gap();
            n_chan = w * h * 3;
            if (flaw == FLAW_EXTRA) n_chan += $urandom_range(1, 3);
            if (flaw == FLAW_SHORT && n_chan > 0) n_chan -= $urandom_range(1, n_chan);
            hit = (n_chan > 0) ? $urandom_range(0, n_chan - 1) : 0;
            for (int i = 0; i < n_chan; i++) begin
               case ($urandom_range(0, 3))
                  0: v = 0;
                  1: v = maxv;
                  default: v = $urandom_range(0, maxv);
               endcase
               if (i == hit && flaw == FLAW_OVER) v = maxv + 1 + $urandom_range(0, 9);
               if (i == hit && flaw == FLAW_DIGITS) put_text("0000000");
               put_number(v);
               if (i != n_chan - 1 || flaw != FLAW_OPEN_END) put_gap();
            end
         end
      end else if (pick < 75) begin
         case ($urandom_range(0, 7))
            0: begin w = 1024; h = 1024; end
            1: begin w = 1025; h = 1024; end
            2: begin w = 1; h = 1048576; end
            3: begin w = 1048576; h = 1; end
            4: begin w = 0; h = 9999999; end
            5: begin w = 9999999; h = 0; end
            6: begin w = 2048; h = 512; end
            default: begin w = 1048577; h = 1; end
         endcase
         put_text("P3 ");
         put_number(w);
         put_gap();
         put_number(h);
         put_gap();
         put_number(255);
         put_gap();
         repeat ($urandom_range(0, 8)) begin
            put_number($urandom_range(0, 255));
            put_gap();
         end
      end else if (pick < 88) begin
         if ($urandom_range(0, 1)) put_text("P3");
         repeat ($urandom_range(4, 24)) file_text.push_back(8'($urandom_range(0, 255)));
      end else begin
         put_text("P3");
         put_gap();
         n_chan = $urandom_range(0, 5);
         for (int i = 0; i < n_chan; i++) begin
            put_number($urandom_range(0, 9999999));
            if (i != n_chan - 1 || $urandom_range(0, 1)) put_gap();
         end
      end
   endfunction

   task automatic send_word(logic [7:0] code, logic eof);
      if (!calm && $urandom_range(0, 11) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= code;
      req_end_of_input <= eof;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_file();
      foreach (file_text[i]) send_word(file_text[i], 1'b0);
      send_word(8'($urandom_range(0, 255)), 1'b1);
      file_text.delete();
   endtask

   initial begin : watchdog
      #20_000_000;
      $display("** ppm_ascii_pixel_parser_top: FAILED **");
      $finish;
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(8'h00, 1'b1);
      put_text("Q");
      send_file();
      put_text("P6 1");
      send_file();
      put_text("P3 1 1 255 0 255 1#z\n2 ");
      send_file();
      put_text("P3 2 1 9 9 0 9 1a2 5 ");
      send_file();
      put_text("P3 1 1 0 0 0 0 0 ");
      send_file();
      put_text("P3 12345678 ");
      send_file();
      put_text("P3 1025 1024 1 ");
      send_file();
      put_text("P3 1 1 5 1 2 3");
      send_file();
      put_text("P3 2 2");
      send_file();
      put_text("P3");
      file_text.push_back(CharTab);
      put_text("0");
      file_text.push_back(CharVt);
      put_text("0");
      file_text.push_back(CharFf);
      put_text("9999999");
      file_text.push_back(CharCr);
      send_file();
      put_text("P3 1024 1024 255 255 255 255 ");
      send_file();
      directed_words = words_sent;

      // hold until the block has drained
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);

      while (words_sent - directed_words < RandomWords) begin
         calm = (words_sent - directed_words > RandomWords - CalmTailWords) ||
                ($urandom_range(0, 3) == 0);
         build_random_file();
         send_file();
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("** ppm_ascii_pixel_parser_top: PASSED **");
      end else begin
         $display("** ppm_ascii_pixel_parser_top: FAILED **");
      end
      $finish;
   end

endmodule
